// File: rtl/pbap_pkg.sv
// Shared types, constants and the page-rounding helper of the pyramid buffer address planner.
// No dependencies; every other file imports this package.
package pbap_pkg;

	// Layout constants
	localparam int DS_LAYERS  = 24;
	localparam int US_LAYERS  = 6;
	localparam int PAGE_BYTES = 4096;
	localparam int MAX_DIM    = 4096;
	localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

	// Field and datapath widths
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 5;
	localparam int DIM_W      = 13;
	localparam int PAD_W      = DIM_W + 1;
	localparam int FACTOR_W   = 8;
	localparam int SIZE_W     = PAD_W + DIM_W;
	localparam int ADDR_W     = 32;
	localparam int CUR_W      = 33;
	localparam int CALC_W     = 35;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DS_MASK_W  = 24;
	localparam int US_MASK_W  = 6;
	localparam int MASK_EXT_W = 32;

	localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h1000_0000;
	localparam logic [ADDR_W-1:0] REGION_RESET = 32'h0200_0000;
	localparam logic [CUR_W-1:0]  ADDR_TOP     = 33'h1_0000_0000;

	// Layer kinds; the fourth code is unused and treated as a skipped layer
	typedef enum logic [KIND_W-1:0] {
		KIND_SOURCE = 2'd0,
		KIND_DOWN   = 2'd1,
		KIND_UP     = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDR    = 3'd0,
		REG_REGION_SIZE  = 3'd1,
		REG_DS_TOP_LAYER = 3'd2,
		REG_DS_UV_SKIP   = 3'd3,
		REG_US_ENABLE    = 3'd4,
		REG_US_UV_SKIP   = 3'd5
	} reg_idx_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [CUR_W-1:0]     base_aligned;
		logic [CUR_W-1:0]     limit;
		logic [IDX_W-1:0]     ds_top_layer;
		logic [DS_MASK_W-1:0] ds_uv_skip;
		logic [US_MASK_W-1:0] us_enable;
		logic [US_MASK_W-1:0] us_uv_skip;
	} cfg_t;

	// One layer item held in the input stage
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [IDX_W-1:0]    layer_index;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [FACTOR_W-1:0] scale_factor;
	} layer_t;

	// Placement decision for one layer
	typedef struct packed {
		logic              place;
		logic              uv_skip;
		logic              is_source;
		logic [SIZE_W-1:0] size;
	} plan_t;

	// Round up to the next page boundary
	function automatic logic [CALC_W-1:0] page_align(input logic [CALC_W-1:0] x);
		logic [CALC_W-1:0] s;
		s = x + CALC_W'(PAGE_BYTES - 1);
		return {s[CALC_W-1:PAGE_BITS], PAGE_BITS'(0)};
	endfunction

endpackage

// File: rtl/pbap_layer_if.sv
// Layer item channel: valid/ready handshake with the layer description.
// Depends on pbap_pkg for field widths.
interface pbap_layer_if import pbap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [IDX_W-1:0]    layer_index;
	logic [DIM_W-1:0]    width;
	logic [DIM_W-1:0]    height;
	logic [FACTOR_W-1:0] scale_factor;

	modport source (output valid, kind, layer_index, width, height, scale_factor,
		input ready);
	modport sink (input valid, kind, layer_index, width, height, scale_factor,
		output ready);
endinterface

// File: rtl/pbap_plan_if.sv
// Result channel: valid/ready handshake with the planned plane addresses.
// Depends on pbap_pkg for field widths.
interface pbap_plan_if import pbap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] y_addr;
	logic [ADDR_W-1:0] c_addr;
	logic              overflow;

	modport source (output valid, y_addr, c_addr, overflow, input ready);
	modport sink (input valid, y_addr, c_addr, overflow, output ready);
endinterface

// File: rtl/pbap_cfg.sv
// Configuration registers of the planner, with the page-aligned base and the
// clamped region limit derived for the datapath. Depends on pbap_pkg.
module pbap_cfg import pbap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [ADDR_W-1:0]    base_q;
	logic [CUR_W-1:0]     base_aligned_q;
	logic [ADDR_W-1:0]    region_q;
	logic [IDX_W-1:0]     ds_top_q;
	logic [DS_MASK_W-1:0] ds_uv_skip_q;
	logic [US_MASK_W-1:0] us_enable_q;
	logic [US_MASK_W-1:0] us_uv_skip_q;
	logic [CUR_W-1:0]     end_sum;
	logic [CALC_W-1:0]    base_al_next;

	assign base_al_next = page_align(CALC_W'(cfg_wdata[ADDR_W-1:0]));

	// Decode writes; the aligned base is worked out when base is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q         <= BASE_RESET;
			base_aligned_q <= CUR_W'(BASE_RESET);
			region_q       <= REGION_RESET;
			ds_top_q       <= '0;
			ds_uv_skip_q   <= '0;
			us_enable_q    <= '0;
			us_uv_skip_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_ADDR: begin
					base_q         <= cfg_wdata[ADDR_W-1:0];
					base_aligned_q <= base_al_next[CUR_W-1:0];
				end
				REG_REGION_SIZE:  region_q     <= cfg_wdata[ADDR_W-1:0];
				REG_DS_TOP_LAYER: ds_top_q     <= cfg_wdata[IDX_W-1:0];
				REG_DS_UV_SKIP:   ds_uv_skip_q <= cfg_wdata[DS_MASK_W-1:0];
				REG_US_ENABLE:    us_enable_q  <= cfg_wdata[US_MASK_W-1:0];
				REG_US_UV_SKIP:   us_uv_skip_q <= cfg_wdata[US_MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the region end to the top of the 32-bit space
	assign end_sum = {1'b0, base_q} + {1'b0, region_q};

	always_comb begin
		cfg.base_aligned = base_aligned_q;
		cfg.limit        = (end_sum > ADDR_TOP) ? ADDR_TOP : end_sum;
		cfg.ds_top_layer = ds_top_q;
		cfg.ds_uv_skip   = ds_uv_skip_q;
		cfg.us_enable    = us_enable_q;
		cfg.us_uv_skip   = us_uv_skip_q;
	end

endmodule

// File: rtl/pbap_decode.sv
// Layer decode: skip rules, chroma bypass, width padding and plane size.
// Depends on pbap_pkg.
module pbap_decode import pbap_pkg::*; (
	input  layer_t layer_in,
	input  cfg_t   cfg,
	output plan_t  plan_out
);

	logic [DIM_W-1:0]      w_clamp;
	logic [DIM_W-1:0]      h_clamp;
	logic [PAD_W-1:0]      w_pad;
	logic [PAD_W-1:0]      w_use;
	logic [MASK_EXT_W-1:0] ds_skip_ext;
	logic [MASK_EXT_W-1:0] us_en_ext;
	logic [MASK_EXT_W-1:0] us_skip_ext;
	logic                  ds_in_range;
	logic                  us_in_range;
	logic                  ds_bypass;
	logic                  place;
	logic                  uv_skip;

	// Saturate oversize dimensions, pad scaled widths to 16
	assign w_clamp = (layer_in.width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : layer_in.width;
	assign h_clamp = (layer_in.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : layer_in.height;
	assign w_pad   = (PAD_W'(w_clamp) + PAD_W'(15)) & ~PAD_W'(15);

	// Masks read as zero beyond their width
	assign ds_skip_ext = MASK_EXT_W'(cfg.ds_uv_skip);
	assign us_en_ext   = MASK_EXT_W'(cfg.us_enable);
	assign us_skip_ext = MASK_EXT_W'(cfg.us_uv_skip);

	assign ds_in_range = ({1'b0, layer_in.layer_index} < (IDX_W + 1)'(DS_LAYERS))
		&& (layer_in.layer_index <= cfg.ds_top_layer);
	assign us_in_range = {1'b0, layer_in.layer_index} < (IDX_W + 1)'(US_LAYERS);
	assign ds_bypass   = (layer_in.layer_index[1:0] != 2'd0)
		&& (layer_in.scale_factor == '0);

	// Decide whether the layer is placed and whether it has a chroma plane
	always_comb begin
		place   = 1'b0;
		uv_skip = 1'b0;
		w_use   = w_pad;
		case (layer_in.kind)
			KIND_SOURCE: begin
				place = 1'b1;
				w_use = PAD_W'(w_clamp);
			end
			KIND_DOWN: begin
				place   = ds_in_range && !ds_bypass;
				uv_skip = ds_skip_ext[layer_in.layer_index];
			end
			KIND_UP: begin
				place   = us_in_range && us_en_ext[layer_in.layer_index];
				uv_skip = us_skip_ext[layer_in.layer_index];
			end
			default: ;
		endcase
	end

	always_comb begin
		plan_out.place     = place;
		plan_out.uv_skip   = uv_skip;
		plan_out.is_source = (layer_in.kind == KIND_SOURCE);
		plan_out.size      = SIZE_W'(w_use) * SIZE_W'(h_clamp);
	end

endmodule

// File: rtl/pbap_cursor.sv
// Layout cursor, latched limit, sticky overflow and the result register.
// Depends on pbap_pkg.
module pbap_cursor import pbap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  plan_t             plan_in,
	input  cfg_t              cfg,
	output logic [ADDR_W-1:0] y_addr,
	output logic [ADDR_W-1:0] c_addr,
	output logic              overflow
);

	logic [CUR_W-1:0]  cursor_q;
	logic [CUR_W-1:0]  limit_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] y_q;
	logic [ADDR_W-1:0] c_q;
	logic              ovf_out_q;

	logic [CUR_W-1:0]  cur_base;
	logic [CUR_W-1:0]  lim;
	logic              ovf_in;
	logic [CALC_W-1:0] c_start;
	logic [CALC_W-1:0] end_raw;
	logic [CALC_W-1:0] end_al;
	logic              active;
	logic              hit;
	logic              commit;
	logic              ovf_next;
	logic [CUR_W-1:0]  cursor_next;

	// A source item restarts from the aligned base and the current limit
	assign cur_base = plan_in.is_source ? cfg.base_aligned : cursor_q;
	assign lim      = plan_in.is_source ? cfg.limit : limit_q;
	assign ovf_in   = plan_in.is_source ? 1'b0 : ovf_q;

	// Place luma, then chroma at half size unless skipped, then realign
	assign c_start = CALC_W'(cur_base) + CALC_W'(plan_in.size);
	assign end_raw = plan_in.uv_skip ? c_start
		: c_start + CALC_W'(plan_in.size >> 1);
	assign end_al  = page_align(end_raw);

	assign active      = plan_in.place && !ovf_in;
	assign hit         = end_al >= CALC_W'(lim);
	assign commit      = active && !hit;
	assign ovf_next    = ovf_in || (active && hit);
	assign cursor_next = commit ? end_al[CUR_W-1:0] : cur_base;

	// Advance layout state on each transfer out of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			limit_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (advance) begin
			cursor_q <= cursor_next;
			limit_q  <= lim;
			ovf_q    <= ovf_next;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			y_q       <= commit ? cur_base[ADDR_W-1:0] : '0;
			c_q       <= (commit && !plan_in.uv_skip) ? c_start[ADDR_W-1:0] : '0;
			ovf_out_q <= ovf_next;
		end
	end

	assign y_addr   = y_q;
	assign c_addr   = c_q;
	assign overflow = ovf_out_q;

endmodule

// File: rtl/pyramid_buffer_address_planner.sv
// Top level of the pyramid buffer address planner: input stage, decode,
// cursor and result register. Depends on pbap_pkg, the channel interfaces,
// pbap_cfg, pbap_decode and pbap_cursor.
//
//  channel   | kind             | carries
//  ----------+------------------+----------------------------------------------
//  layer     | valid/ready sink | kind, layer_index, width, height, scale_factor
//  plan      | valid/ready src  | y_addr, c_addr, overflow
//  cfg_*     | write only       | cfg_index, cfg_wdata under cfg_wr_en
//
// One layer per cycle while the result channel is not stalled; a result is
// registered after its layer has passed through the input register.
// The cursor update (multiply, two adds, page rounding and limit compare)
// is combinational from the input register into the result register.
// A stalled result holds in the result register while one more layer waits
// in the input register. Reset clears the cursor, limit and overflow flag.
module pyramid_buffer_address_planner import pbap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pbap_layer_if.sink            layer,
	pbap_plan_if.source           plan,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t   cfg;
	layer_t layer_s1;
	logic   valid_s1;
	logic   plan_valid_q;
	logic   plan_free;
	logic   advance;
	plan_t  dec;

	pbap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: the input stage drains whenever the result register can take
	assign plan_free   = !plan_valid_q || plan.ready;
	assign advance     = valid_s1 && plan_free;
	assign layer.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			plan_valid_q <= 1'b0;
		end else begin
			if (layer.ready) begin
				valid_s1 <= layer.valid;
			end
			if (plan_free) begin
				plan_valid_q <= valid_s1;
			end
		end
	end

	// Capture the layer on each input transfer
	always_ff @(posedge clk) begin
		if (layer.valid && layer.ready) begin
			layer_s1.kind         <= layer.kind;
			layer_s1.layer_index  <= layer.layer_index;
			layer_s1.width        <= layer.width;
			layer_s1.height       <= layer.height;
			layer_s1.scale_factor <= layer.scale_factor;
		end
	end

	pbap_decode u_decode (
		.layer_in (layer_s1),
		.cfg      (cfg),
		.plan_out (dec)
	);

	pbap_cursor u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.plan_in  (dec),
		.cfg      (cfg),
		.y_addr   (plan.y_addr),
		.c_addr   (plan.c_addr),
		.overflow (plan.overflow)
	);

	assign plan.valid = plan_valid_q;

endmodule

// File: rtl/pbap_checker.sv
// Port-level checks on the planner's result channel, bound to the top level.
// Depends on pbap_pkg and pyramid_buffer_address_planner.
module pbap_checker import pbap_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              plan_valid,
	input logic              plan_ready,
	input logic [ADDR_W-1:0] y_addr,
	input logic [ADDR_W-1:0] c_addr,
	input logic              overflow
);

	// A stalled result holds
	a_plan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && !plan_ready |=> plan_valid && $stable(y_addr)
			&& $stable(c_addr) && $stable(overflow))
		else $error("result changed while stalled");

	// An exhausted region gives no addresses
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && overflow |-> y_addr == '0 && c_addr == '0)
		else $error("address given with overflow set");

	// Luma planes start on a page
	a_y_page: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid |-> (y_addr & ADDR_W'(PAGE_BYTES - 1)) == '0)
		else $error("luma address not page aligned");

	// Chroma follows luma
	a_c_order: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid && c_addr != '0 |-> c_addr >= y_addr)
		else $error("chroma placed below luma");

endmodule

bind pyramid_buffer_address_planner pbap_checker u_pbap_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.plan_valid (plan.valid),
	.plan_ready (plan.ready),
	.y_addr     (plan.y_addr),
	.c_addr     (plan.c_addr),
	.overflow   (plan.overflow)
);

// File: dv/testbench.sv
// Self-checking testbench of the pyramid buffer address planner.
// Drives layer items, predicts each plane layout and checks every result.
// Depends on pbap_pkg, pbap_layer_if, pbap_plan_if and the planner itself.
module testbench;
	import pbap_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [IDX_W-1:0]    index;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [FACTOR_W-1:0] factor;
		logic                hold_for_drain;
	} layer_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] y_addr;
		logic [ADDR_W-1:0] c_addr;
		logic              overflow;
	} plane_addrs_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pbap_layer_if layer_ch();
	pbap_plan_if  plan_ch();

	pyramid_buffer_address_planner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.layer     (layer_ch),
		.plan      (plan_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow registers and layout state of the predictor
	logic [ADDR_W-1:0]    cfg_base;
	logic [ADDR_W-1:0]    cfg_region;
	logic [IDX_W-1:0]     cfg_ds_top;
	logic [DS_MASK_W-1:0] cfg_ds_uv_skip;
	logic [US_MASK_W-1:0] cfg_us_enable;
	logic [US_MASK_W-1:0] cfg_us_uv_skip;
	logic [CUR_W-1:0]     layout_cursor;
	logic [CUR_W-1:0]     layout_limit;
	logic                 layout_full;

	layer_item_t  pending_layers[$];
	plane_addrs_t planned_addrs[$];
	layer_item_t  shown_layer;
	plane_addrs_t wanted;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           mismatches;
	int           quiet_cycles;
	int           phase;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] round_to_page(input logic [63:0] x);
		return ((x + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
	endfunction

	// Lay out one layer and return the addresses the block must report
	function automatic plane_addrs_t plan_layer(input layer_item_t it);
		logic [63:0]  w, h, size, next, luma, chroma, sum;
		logic         place, no_chroma;
		plane_addrs_t res;
		w = 64'(it.width);
		h = 64'(it.height);
		if (w > MAX_DIM) w = 64'(MAX_DIM);
		if (h > MAX_DIM) h = 64'(MAX_DIM);
		place = 1'b0;
		no_chroma = 1'b0;
		res = '0;
		case (it.kind)
			KIND_SOURCE: begin
				// restart at the aligned base and latch the limit
				sum = 64'(cfg_base) + 64'(cfg_region);
				layout_limit = (sum > 64'(ADDR_TOP)) ? ADDR_TOP : sum[CUR_W-1:0];
				next = round_to_page(64'(cfg_base));
				layout_cursor = next[CUR_W-1:0];
				layout_full = 1'b0;
				place = 1'b1;
			end
			KIND_DOWN: begin
				if (it.index < DS_LAYERS && it.index <= cfg_ds_top &&
				    !(it.index[1:0] != 2'd0 && it.factor == '0)) begin
					place = 1'b1;
					no_chroma = cfg_ds_uv_skip[it.index];
					w = (w + 64'd15) & ~64'd15;
				end
			end
			KIND_UP: begin
				if (it.index < US_LAYERS && cfg_us_enable[it.index]) begin
					place = 1'b1;
					no_chroma = cfg_us_uv_skip[it.index];
					w = (w + 64'd15) & ~64'd15;
				end
			end
			default: ;
		endcase
		if (place && !layout_full) begin
			size = w * h;
			luma = 64'(layout_cursor);
			chroma = '0;
			next = luma + size;
			if (!no_chroma) begin
				chroma = next;
				next = next + (size >> 1);
			end
			next = round_to_page(next);
			if (next >= 64'(layout_limit)) begin
				layout_full = 1'b1;
			end else begin
				layout_cursor = next[CUR_W-1:0];
				res.y_addr = luma[ADDR_W-1:0];
				res.c_addr = chroma[ADDR_W-1:0];
			end
		end
		res.overflow = layout_full;
		return res;
	endfunction

	// Layer driver: present queued items, predict each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_ch.valid <= 1'b0;
		end else begin
			if (layer_ch.valid && layer_ch.ready)
				planned_addrs.push_back(plan_layer(shown_layer));
			if (!layer_ch.valid || layer_ch.ready) begin
				if (pending_layers.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(pending_layers[0].hold_for_drain && planned_addrs.size() != 0)) begin
					shown_layer = pending_layers.pop_front();
					layer_ch.valid        <= 1'b1;
					layer_ch.kind         <= shown_layer.kind;
					layer_ch.layer_index  <= shown_layer.index;
					layer_ch.width        <= shown_layer.width;
					layer_ch.height       <= shown_layer.height;
					layer_ch.scale_factor <= shown_layer.factor;
				end else begin
					layer_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_result(input string why);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: exp y=%h c=%h ovf=%b, got y=%h c=%h ovf=%b", why,
				wanted.y_addr, wanted.c_addr, wanted.overflow,
				plan_ch.y_addr, plan_ch.c_addr, plan_ch.overflow);
	endtask

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_ch.ready <= 1'b0;
		end else begin
			if (plan_ch.valid && plan_ch.ready) begin
				if (planned_addrs.size() == 0) begin
					wanted = '0;
					flag_result("unexpected result");
				end else begin
					wanted = planned_addrs.pop_front();
					if (plan_ch.y_addr !== wanted.y_addr || plan_ch.c_addr !== wanted.c_addr ||
					    plan_ch.overflow !== wanted.overflow)
						flag_result("address mismatch");
				end
			end
			plan_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (layer_ch.valid && layer_ch.ready) || (plan_ch.valid && plan_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_BASE_ADDR:    cfg_base = val;
			REG_REGION_SIZE:  cfg_region = val;
			REG_DS_TOP_LAYER: cfg_ds_top = val[IDX_W-1:0];
			REG_DS_UV_SKIP:   cfg_ds_uv_skip = val[DS_MASK_W-1:0];
			REG_US_ENABLE:    cfg_us_enable = val[US_MASK_W-1:0];
			REG_US_UV_SKIP:   cfg_us_uv_skip = val[US_MASK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] base, input logic [31:0] region,
		input logic [31:0] top, input logic [31:0] ds_skip, input logic [31:0] us_en,
		input logic [31:0] us_skip);
		write_reg(REG_BASE_ADDR, base);
		write_reg(REG_REGION_SIZE, region);
		write_reg(REG_DS_TOP_LAYER, top);
		write_reg(REG_DS_UV_SKIP, ds_skip);
		write_reg(REG_US_ENABLE, us_en);
		write_reg(REG_US_UV_SKIP, us_skip);
	endtask

	// Hold until every queued layer has its result back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_layers.size() != 0 || layer_ch.valid || planned_addrs.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_layer(input logic [KIND_W-1:0] kind, input int idx, input int w,
		input int h, input int f, input logic hold);
		layer_item_t it;
		it.kind = kind;
		it.index = IDX_W'(idx);
		it.width = DIM_W'(w);
		it.height = DIM_W'(h);
		it.factor = FACTOR_W'(f);
		it.hold_for_drain = hold;
		pending_layers.push_back(it);
	endtask

	// Mostly small planes so several layers fit before the region fills
	function automatic int rand_dim();
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) return $urandom_range(255);
		if (pick < 95) return $urandom_range(MAX_DIM);
		return $urandom_range(8191);
	endfunction

	// Source-led layer sequences with random content, plus some noise
	task automatic queue_random(input int count);
		int n, k, j, pick, idx, f;
		logic [KIND_W-1:0] kind;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) == 0) begin
				add_layer(KIND_W'($urandom_range(3)), $urandom_range(31), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(255), 1'b0);
				n++;
			end else begin
				add_layer(KIND_SOURCE, $urandom_range(31), rand_dim(), rand_dim(),
					$urandom_range(255), 1'b0);
				k = $urandom_range(1, 12);
				for (j = 0; j < k; j++) begin
					pick = $urandom_range(99);
					f = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 255);
					if (pick < 60) begin
						kind = KIND_DOWN;
						idx = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
					end else if (pick < 95) begin
						kind = KIND_UP;
						idx = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(5);
					end else begin
						kind = KIND_SPARE;
						idx = $urandom_range(31);
					end
					add_layer(kind, idx, rand_dim(), rand_dim(), f, $urandom_range(99) == 0);
				end
				n += k + 1;
			end
		end
	endtask

	task automatic random_config();
		logic [31:0] base, region;
		case ($urandom_range(3))
			0: base = $urandom;
			1: base = $urandom_range(32'hFFFF_FFFF, 32'hFF00_0000);
			default: base = $urandom_range(32'h4000_0000);
		endcase
		region = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0200_0000, 32'h0001_0000);
		set_config(base, region, $urandom_range(23), $urandom, $urandom, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		layer_ch.valid = 1'b0;
		layer_ch.kind = '0;
		layer_ch.layer_index = '0;
		layer_ch.width = '0;
		layer_ch.height = '0;
		layer_ch.scale_factor = '0;
		plan_ch.ready = 1'b0;
		cfg_base = BASE_RESET;
		cfg_region = REGION_RESET;
		cfg_ds_top = '0;
		cfg_ds_uv_skip = '0;
		cfg_us_enable = '0;
		cfg_us_uv_skip = '0;
		layout_cursor = '0;
		layout_limit = '0;
		layout_full = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 10;
		recv_idle_pct = 58;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// A layer before any source meets a zero limit
		add_layer(KIND_DOWN, 0, 64, 64, 0, 1'b0);
		wait_idle();

		set_config(32'h1000_0800, 32'h0200_0000, 23, 32'h0000_F0F0, 32'h0000_002D,
			32'h0000_0005);
		add_layer(KIND_SOURCE, 0, 4096, 16, 0, 1'b0);
		add_layer(KIND_DOWN, 0, 1, 1, 0, 1'b0);
		add_layer(KIND_DOWN, 1, 100, 100, 0, 1'b0);
		add_layer(KIND_DOWN, 1, 8191, 8191, 255, 1'b0);
		add_layer(KIND_DOWN, 4, 100, 0, 1, 1'b0);
		add_layer(KIND_DOWN, 23, 17, 3, 1, 1'b0);
		add_layer(KIND_DOWN, 24, 16, 16, 1, 1'b0);
		add_layer(KIND_DOWN, 31, 16, 16, 1, 1'b0);
		add_layer(KIND_UP, 0, 33, 2, 0, 1'b0);
		add_layer(KIND_UP, 1, 16, 16, 0, 1'b0);
		add_layer(KIND_UP, 5, 16, 16, 0, 1'b0);
		add_layer(KIND_UP, 6, 16, 16, 0, 1'b0);
		add_layer(KIND_UP, 31, 16, 16, 0, 1'b0);
		add_layer(KIND_SPARE, 31, 8191, 8191, 255, 1'b0);
		add_layer(KIND_DOWN, 8, 4096, 4096, 2, 1'b0);
		add_layer(KIND_UP, 2, 1, 1, 0, 1'b1);
		add_layer(KIND_SOURCE, 0, 0, 0, 0, 1'b0);
		wait_idle();

		// Aligned base lands on 4 GiB: the source itself overflows
		set_config(32'hFFFF_F001, 32'hFFFF_FFFF, 0, 32'h00FF_FFFF, 32'h0000_003F,
			32'h0000_003F);
		add_layer(KIND_SOURCE, 0, 16, 16, 0, 1'b0);
		add_layer(KIND_DOWN, 0, 16, 16, 0, 1'b0);
		wait_idle();

		// A plane running past 4 GiB flags overflow
		set_config(32'hFFFF_0000, 32'h0001_0000, 23, 0, 32'h0000_003F, 0);
		add_layer(KIND_SOURCE, 0, 16, 16, 0, 1'b0);
		add_layer(KIND_UP, 3, 4096, 4096, 0, 1'b0);
		wait_idle();

		// Empty region, then the whole address space from zero
		set_config(0, 0, 0, 0, 0, 0);
		add_layer(KIND_SOURCE, 0, 1, 1, 0, 1'b0);
		wait_idle();
		set_config(0, 32'hFFFF_FFFF, 0, 32'h00FF_FFFF, 32'h0000_003F, 32'h0000_003F);
		add_layer(KIND_SOURCE, 0, 4096, 4096, 0, 1'b0);
		add_layer(KIND_DOWN, 0, 4096, 4096, 0, 1'b0);
		add_layer(KIND_DOWN, 4, 16, 16, 9, 1'b0);

		// Random phases: sender lightly idle, then receiver lightly idle, then no idling
		for (phase = 0; phase < 6; phase++) begin
			wait_idle();
			send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 58 : 0;
			recv_idle_pct = (phase < 2) ? 58 : (phase < 4) ? 10 : 0;
			random_config();
			queue_random(185);
		end
		wait_idle();
		repeat (8) @(negedge clk);

		if (mismatches == 0 && planned_addrs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
